/* rtl/mrmtd_pkg.sv */
// Shared types and constants for the motor reply multi-turn decoder.
`timescale 1ns / 1ps

package mrmtd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CURRENT_GAIN = 2'd0,
    REG_WRAP_HIGH    = 2'd1,
    REG_WRAP_LOW     = 2'd2
  } reg_idx_e;

  // Register reset values
  localparam logic [15:0] CurrentGainRst = 16'd1082;
  localparam logic [15:0] WrapHighRst    = 16'd54614;
  localparam logic [15:0] WrapLowRst     = 16'd10922;

  // Field widths
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 120;
  localparam int unsigned AngleW    = 30;
  localparam int unsigned MagW      = 32;
  localparam int unsigned RecipW    = 33;

  // Saturation bounds of the output angle
  localparam logic [AngleW-1:0] AngleMax = {1'b0, {(AngleW-1){1'b1}}};
  localparam logic [AngleW-1:0] AngleMin = {1'b1, {(AngleW-1){1'b0}}};

  // Encoder position to Q16 degrees
  localparam logic [8:0] DegPerTurn = 9'd360;

  // Data carried along the angle pipeline
  typedef struct packed {
    logic [31:0] current_scaled;
    logic [15:0] velocity;
    logic [24:0] position_degrees;
    logic [15:0] turns;
    logic        first;
  } side_t;

endpackage

/* rtl/motor_reply_multiturn_decoder_unit.sv */
// Motor status reply decoder: current scaling, velocity, degrees and multi-turn angle.
`timescale 1ns / 1ps
// A reply passes through the input register, stages 1 to 4 and the result register.
// Throughput: one reply per cycle; all stages advance together whenever the
// result register is empty or taken. The angle divide by GEAR_RATIO is a
// reciprocal multiply split into two 16-bit partial products over two stages.
// Reset clears all valid bits, the turn counter, the first-reply flag and
// loads the configuration registers with their defaults.

module motor_reply_multiturn_decoder_unit #(
  parameter int unsigned GEAR_RATIO = 6,
  parameter int unsigned TURN_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // Reply input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: byte2, byte3, byte4, byte5, byte6, byte7 (from bit 0 up)
  input  logic [mrmtd_pkg::InTdataW-1:0] s_axis_tdata,
  // Result output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: current_scaled[31:0], velocity[47:32], position_degrees[72:48],
  //        turns[88:73], output_angle[118:89], zero pad[119]
  output logic [mrmtd_pkg::OutTdataW-1:0] m_axis_tdata
);

  // Divide constants: q = (n * RecipM) >> (32 + ShiftL), exact for 32-bit n
  localparam int unsigned ShiftL = $clog2(GEAR_RATIO);
  localparam logic [64:0] RecipFull =
      (65'd1 << (32 + ShiftL)) / 65'(GEAR_RATIO) + 65'd1;
  localparam logic [mrmtd_pkg::RecipW-1:0] RecipM = RecipFull[mrmtd_pkg::RecipW-1:0];

  // Turn counter limits
  localparam int unsigned TurnBitsEff = (TURN_BITS > 16) ? 16 : TURN_BITS;
  localparam logic signed [15:0] TurnMax = 16'((32'd1 << (TurnBitsEff - 1)) - 32'd1);
  localparam logic signed [15:0] TurnMin = -TurnMax - 16'sd1;

  // Pipeline advance
  logic adv;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign adv           = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid_q;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  logic [15:0] gain_q, wrap_high_q, wrap_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= mrmtd_pkg::CurrentGainRst;
      wrap_high_q <= mrmtd_pkg::WrapHighRst;
      wrap_low_q  <= mrmtd_pkg::WrapLowRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mrmtd_pkg::REG_CURRENT_GAIN: gain_q      <= cfg_data_i;
        mrmtd_pkg::REG_WRAP_HIGH:    wrap_high_q <= cfg_data_i;
        mrmtd_pkg::REG_WRAP_LOW:     wrap_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= s_axis_tvalid;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Stage 0: input register
  logic [mrmtd_pkg::InTdataW-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
  end

  logic signed [15:0] cur_raw;
  logic [15:0]        vel_raw;
  logic [15:0]        pos;

  assign cur_raw = $signed(in_q[15:0]);
  assign vel_raw = in_q[31:16];
  assign pos     = in_q[47:32];

  // Tracking state
  logic               seen_first_q, seen_first_d;
  logic [15:0]        prev_pos_q, prev_pos_d;
  logic signed [15:0] turn_q, turn_d;
  logic [15:0]        bias_q, bias_d;
  logic signed [15:0] turn_inc;
  logic               fwd_wrap, bwd_wrap;
  logic signed [16:0] pos_diff;

  // Detect wraps, step the saturating turn counter, latch the bias once
  always_comb begin
    fwd_wrap     = (prev_pos_q >= wrap_high_q) && (pos <= wrap_low_q);
    bwd_wrap     = (prev_pos_q <= wrap_low_q) && (pos >= wrap_high_q);
    turn_inc     = (fwd_wrap && (turn_q < TurnMax)) ? turn_q + 16'sd1 : turn_q;
    seen_first_d = 1'b1;
    prev_pos_d   = pos;
    bias_d       = bias_q;
    turn_d       = turn_q;
    if (!seen_first_q) begin
      bias_d = pos;
    end else begin
      turn_d = (bwd_wrap && (turn_inc > TurnMin)) ? turn_inc - 16'sd1 : turn_inc;
    end
    pos_diff = $signed({1'b0, pos}) - $signed({1'b0, bias_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_first_q <= 1'b0;
      prev_pos_q   <= 16'd0;
      turn_q       <= 16'sd0;
      bias_q       <= 16'd0;
    end else if (adv && v0_q) begin
      seen_first_q <= seen_first_d;
      prev_pos_q   <= prev_pos_d;
      turn_q       <= turn_d;
      bias_q       <= bias_d;
    end
  end

  // Stage 1: scaled current, degrees, new turn count and position offset
  mrmtd_pkg::side_t   s1_q, s2_q, s3_q, s4_q;
  logic signed [16:0] diff1_q;
  logic signed [32:0] cur_prod;

  assign cur_prod = cur_raw * $signed({1'b0, gain_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.current_scaled   <= cur_prod[31:0];
      s1_q.velocity         <= vel_raw;
      s1_q.position_degrees <= 25'(pos) * 25'(mrmtd_pkg::DegPerTurn);
      s1_q.turns            <= turn_d;
      s1_q.first            <= ~seen_first_q;
      diff1_q               <= pos_diff;
    end
  end

  // Stage 2: unwrapped count as sign and magnitude
  logic signed [32:0]         num;
  logic [32:0]                num_abs;
  logic [mrmtd_pkg::MagW-1:0] mag2_q;
  logic                       neg2_q;

  assign num     = $signed({s1_q.turns, 16'd0}) + 33'(diff1_q);
  assign num_abs = num[32] ? 33'(-num) : num;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q   <= s1_q;
      mag2_q <= num_abs[mrmtd_pkg::MagW-1:0];
      neg2_q <= num[32];
    end
  end

  // Stage 3: reciprocal partial products
  logic [48:0] plo3_q, phi3_q;
  logic        neg3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q   <= s2_q;
      plo3_q <= mag2_q[15:0] * RecipM;
      phi3_q <= mag2_q[31:16] * RecipM;
      neg3_q <= neg2_q;
    end
  end

  // Stage 4: combine partial products and shift out the quotient
  logic [64:0]                prod;
  logic [64:0]                quo_wide;
  logic [mrmtd_pkg::MagW-1:0] qmag4_q;
  logic                       neg4_q;

  assign prod     = {16'd0, plo3_q} + {phi3_q, 16'd0};
  assign quo_wide = prod >> (32 + ShiftL);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q    <= s3_q;
      qmag4_q <= quo_wide[mrmtd_pkg::MagW-1:0];
      neg4_q  <= neg3_q;
    end
  end

  // Stage 5: apply sign, saturate (zero angle for the first reply), and hold the result
  logic [mrmtd_pkg::AngleW-1:0]    angle;
  logic [mrmtd_pkg::OutTdataW-1:0] out_q;

  always_comb begin
    if (s4_q.first) begin
      angle = '0;
    end else if (neg4_q) begin
      if (qmag4_q > {{(mrmtd_pkg::MagW-mrmtd_pkg::AngleW){1'b0}}, mrmtd_pkg::AngleMin}) begin
        angle = mrmtd_pkg::AngleMin;
      end else begin
        angle = -qmag4_q[mrmtd_pkg::AngleW-1:0];
      end
    end else begin
      if (qmag4_q > {{(mrmtd_pkg::MagW-mrmtd_pkg::AngleW){1'b0}}, mrmtd_pkg::AngleMax}) begin
        angle = mrmtd_pkg::AngleMax;
      end else begin
        angle = qmag4_q[mrmtd_pkg::AngleW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {1'b0, angle, s4_q.turns, s4_q.position_degrees,
                s4_q.velocity, s4_q.current_scaled};
    end
  end

  assign m_axis_tdata = out_q;

endmodule
